/* rtl/itp_pkg.sv */
// Shared types, codes and character helpers for the infix to postfix converter.
package itp_pkg;

   typedef logic [2:0] code_type;
   typedef logic [1:0] prec_type;
   typedef logic [7:0] char_type;

   localparam code_type CODE_LPAREN = 3'd0;
   localparam code_type CODE_PLUS   = 3'd1;
   localparam code_type CODE_MINUS  = 3'd2;
   localparam code_type CODE_MUL    = 3'd3;
   localparam code_type CODE_DIV    = 3'd4;

   localparam char_type CHAR_PLUS   = 8'h2B;
   localparam char_type CHAR_MINUS  = 8'h2D;
   localparam char_type CHAR_MUL    = 8'h2A;
   localparam char_type CHAR_DIV    = 8'h2F;
   localparam char_type CHAR_LPAREN = 8'h28;
   localparam char_type CHAR_RPAREN = 8'h29;
   localparam char_type CHAR_SPACE  = 8'h20;

   // One stack entry as held by a cell.
   typedef struct packed {
      logic     valid;
      code_type code;
   } entry_type;

   // Command from the sequencer to the cell chain.
   typedef struct packed {
      logic     push;
      logic     pop;
      code_type code;
   } stack_op_type;

   // What the sequencer sees of the chain.
   typedef struct packed {
      entry_type top;
      logic      full;
   } stack_stat_type;

   function automatic char_type code_char(input code_type code);
      char_type c;
      unique case (code)
         CODE_LPAREN: c = CHAR_LPAREN;
         CODE_PLUS:   c = CHAR_PLUS;
         CODE_MINUS:  c = CHAR_MINUS;
         CODE_MUL:    c = CHAR_MUL;
         CODE_DIV:    c = CHAR_DIV;
         default:     c = CHAR_LPAREN;
      endcase
      return c;
   endfunction

   function automatic prec_type prec_of(input code_type code);
      prec_type p;
      unique case (code)
         CODE_PLUS, CODE_MINUS: p = 2'd1;
         CODE_MUL, CODE_DIV:    p = 2'd2;
         default:               p = 2'd0;
      endcase
      return p;
   endfunction

   function automatic logic is_alnum(input char_type c);
      return ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
             ((c >= 8'h61) && (c <= 8'h7A));
   endfunction

endpackage

/* rtl/itp_cell.sv */
// One stack cell: holds an entry and shifts toward or away from the top.
module itp_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              shift_down,
   input  logic              shift_up,
   input  itp_pkg::entry_type upper,
   input  itp_pkg::entry_type lower,
   output itp_pkg::entry_type entry
);

   logic              valid_ff, valid_in;
   itp_pkg::code_type code_ff, code_in;

   always_comb begin
      valid_in = valid_ff;
      code_in  = code_ff;
      if (shift_down) begin
         valid_in = upper.valid;
         code_in  = upper.code;
      end else if (shift_up) begin
         valid_in = lower.valid;
         code_in  = lower.code;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      code_ff <= code_in;
   end

   assign entry.valid = valid_ff;
   assign entry.code  = code_ff;

endmodule

/* rtl/itp_seq.sv */
// Sequencer: walks one character through push, pop and flush steps and emits results.
module itp_seq (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [7:0]               req_tdata,
   input  logic                     req_tlast,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [7:0]               rsp_tdata,
   output logic                     rsp_tlast,
   output logic [1:0]               rsp_tuser,
   output itp_pkg::stack_op_type    stack_op,
   input  itp_pkg::stack_stat_type  stack_stat
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_MAIN  = 2'd1;
   localparam logic [1:0] S_FLUSH = 2'd2;

   logic [1:0]         state_ff, state_in;
   itp_pkg::char_type  sym_ff, sym_in;
   logic               end_ff, end_in;
   logic               ovf_ff, ovf_in;
   logic               pend_valid_ff, pend_valid_in;
   itp_pkg::char_type  pend_sym_ff, pend_sym_in;
   logic               pend_ovf_ff, pend_ovf_in;
   logic               rsp_valid_ff, rsp_valid_in;
   itp_pkg::char_type  rsp_sym_ff, rsp_sym_in;
   logic               rsp_last_ff, rsp_last_in;
   logic               rsp_done_ff, rsp_done_in;
   logic               rsp_ovf_ff, rsp_ovf_in;

   logic               adv, accept, out_load;
   logic               emit, fin, push, pop, set_ovf, main_done;
   logic [1:0]         next_state;
   itp_pkg::char_type  emit_sym;
   itp_pkg::code_type  op_code, push_code;
   logic               is_op, top_ge;

   always_comb begin
      is_op   = 1'b1;
      op_code = itp_pkg::CODE_PLUS;
      unique case (sym_ff)
         itp_pkg::CHAR_PLUS:  op_code = itp_pkg::CODE_PLUS;
         itp_pkg::CHAR_MINUS: op_code = itp_pkg::CODE_MINUS;
         itp_pkg::CHAR_MUL:   op_code = itp_pkg::CODE_MUL;
         itp_pkg::CHAR_DIV:   op_code = itp_pkg::CODE_DIV;
         default:             is_op = 1'b0;
      endcase
   end

   assign top_ge = stack_stat.top.valid &&
                   (itp_pkg::prec_of(stack_stat.top.code) >= itp_pkg::prec_of(op_code));

   // The sequencer only steps while the output register has room.
   assign adv = (state_ff != S_IDLE) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      emit       = 1'b0;
      emit_sym   = itp_pkg::code_char(stack_stat.top.code);
      fin        = 1'b0;
      push       = 1'b0;
      pop        = 1'b0;
      push_code  = op_code;
      set_ovf    = 1'b0;
      main_done  = 1'b0;
      next_state = state_ff;
      unique case (state_ff)
         S_MAIN: begin
            priority if (itp_pkg::is_alnum(sym_ff)) begin
               emit      = 1'b1;
               emit_sym  = sym_ff;
               main_done = 1'b1;
            end else if (sym_ff == itp_pkg::CHAR_LPAREN) begin
               push_code = itp_pkg::CODE_LPAREN;
               set_ovf   = stack_stat.full;
               push      = !stack_stat.full;
               main_done = 1'b1;
            end else if (sym_ff == itp_pkg::CHAR_RPAREN) begin
               if (stack_stat.top.valid && (stack_stat.top.code != itp_pkg::CODE_LPAREN)) begin
                  pop  = 1'b1;
                  emit = 1'b1;
               end else begin
                  // Discard the matching open paren if there is one.
                  pop       = stack_stat.top.valid;
                  main_done = 1'b1;
               end
            end else if (is_op) begin
               if (top_ge) begin
                  pop  = 1'b1;
                  emit = 1'b1;
               end else begin
                  set_ovf   = stack_stat.full;
                  push      = !stack_stat.full;
                  main_done = 1'b1;
               end
            end else begin
               main_done = 1'b1;
            end
            if (main_done) begin
               if (end_ff) begin
                  next_state = S_FLUSH;
               end else begin
                  fin = 1'b1;
               end
            end
         end
         S_FLUSH: begin
            if (stack_stat.top.valid) begin
               pop  = 1'b1;
               emit = (stack_stat.top.code != itp_pkg::CODE_LPAREN);
            end else begin
               fin = 1'b1;
            end
         end
         S_IDLE: begin
         end
         default: begin
         end
      endcase
   end

   assign req_tready = (state_ff == S_IDLE) || (adv && fin);
   assign accept     = req_tvalid && req_tready;

   // A result waits in the pending slot until it is known whether another follows.
   assign out_load = adv && ((emit && (pend_valid_ff || fin)) || (fin && pend_valid_ff));

   always_comb begin
      rsp_valid_in = out_load ? 1'b1 : (rsp_valid_ff && !rsp_tready);
      rsp_sym_in   = rsp_sym_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_done_in  = rsp_done_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      if (out_load) begin
         if (emit && fin) begin
            rsp_sym_in = emit_sym;
            rsp_ovf_in = ovf_ff;
         end else begin
            rsp_sym_in = pend_sym_ff;
            rsp_ovf_in = pend_ovf_ff;
         end
         rsp_last_in = fin;
         rsp_done_in = fin && end_ff;
      end

      pend_valid_in = pend_valid_ff;
      pend_sym_in   = pend_sym_ff;
      pend_ovf_in   = pend_ovf_ff;
      if (adv && emit && !fin) begin
         pend_valid_in = 1'b1;
         pend_sym_in   = emit_sym;
         pend_ovf_in   = ovf_ff;
      end else if (adv && fin) begin
         pend_valid_in = 1'b0;
      end

      ovf_in = ovf_ff;
      if (adv && set_ovf) begin
         ovf_in = 1'b1;
      end
      if (adv && fin && end_ff) begin
         ovf_in = 1'b0;
      end

      state_in = state_ff;
      sym_in   = sym_ff;
      end_in   = end_ff;
      if (accept) begin
         state_in = S_MAIN;
         sym_in   = req_tdata;
         end_in   = req_tlast;
      end else if (adv && fin) begin
         state_in = S_IDLE;
      end else if (adv) begin
         state_in = next_state;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         ovf_ff        <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         ovf_ff        <= ovf_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      sym_ff      <= sym_in;
      end_ff      <= end_in;
      pend_sym_ff <= pend_sym_in;
      pend_ovf_ff <= pend_ovf_in;
      rsp_sym_ff  <= rsp_sym_in;
      rsp_last_ff <= rsp_last_in;
      rsp_done_ff <= rsp_done_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

   assign stack_op.push = adv && push;
   assign stack_op.pop  = adv && pop;
   assign stack_op.code = push_code;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_sym_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = {rsp_ovf_ff, rsp_done_ff};

   a_push_not_full: assert property (@(posedge clock) disable iff (reset)
      stack_op.push |-> !stack_stat.full)
      else $error("push issued onto a full stack");

   a_pop_not_empty: assert property (@(posedge clock) disable iff (reset)
      stack_op.pop |-> stack_stat.top.valid)
      else $error("pop issued on an empty stack");

   a_one_stack_op: assert property (@(posedge clock) disable iff (reset)
      !(stack_op.push && stack_op.pop))
      else $error("push and pop in the same cycle");

   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !pend_valid_ff)
      else $error("pending result left behind after a transaction finished");

   a_direct_emit_empty: assert property (@(posedge clock) disable iff (reset)
      (adv && emit && fin) |-> !pend_valid_ff)
      else $error("direct result would overtake a pending one");

endmodule

/* rtl/infix_to_postfix_converter.sv */
// Top level of the shunting-yard infix to postfix converter.
//
// Usage: feed one ASCII character per req_ transaction, req_tlast set on the final
// character of an expression. Letters and digits come back on rsp_ at once; operators
// are held in a chain of STACK_DEPTH cells, where the top cell is cell zero and a push
// or pop shifts every cell one place in the same cycle.
// For each character the sequencer first pops and emits every stacked operator that
// it displaces, then handles the character; a matching open paren is dropped in that
// last step. At end of expression a flush then pops every stacked entry and emits all
// but open parens. A result reaches the rsp_ output register directly or through a
// pending slot, where it waits to learn whether it is the last one of its transaction.
// rsp_tlast marks the last result caused by one input character, rsp_tuser[0] the final
// character of the postfix expression, rsp_tuser[1] an earlier push dropped on a full
// stack. A character that produces nothing (a space, a push) gives no rsp_ transaction.
// While rsp_tready is low and the output register is full, the sequencer and the stack
// hold still; req_tready is high while the sequencer is idle and in the step that
// finishes a character. Reset empties the stack and clears the overflow flag and
// all valid flags; no clearing pass is needed.
module infix_to_postfix_converter #(
   parameter int STACK_DEPTH = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // symbol_in[7:0]
   input  logic       req_tlast,   // expr_end
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // symbol_out[7:0]
   output logic       rsp_tlast,   // run_last
   output logic [1:0] rsp_tuser    // postfix_done, stack_overflow
);

   itp_pkg::stack_op_type   stack_op;
   itp_pkg::stack_stat_type stack_stat;
   itp_pkg::entry_type      entries [STACK_DEPTH];
   itp_pkg::entry_type      push_entry;
   itp_pkg::entry_type      empty_entry;

   assign push_entry.valid  = 1'b1;
   assign push_entry.code   = stack_op.code;
   assign empty_entry.valid = 1'b0;
   assign empty_entry.code  = itp_pkg::CODE_LPAREN;

   for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
      itp_pkg::entry_type upper;
      itp_pkg::entry_type lower;
      if (i == 0) begin : g_top
         assign upper = push_entry;
      end else begin : g_mid
         assign upper = entries[i-1];
      end
      if (i == STACK_DEPTH - 1) begin : g_bottom
         assign lower = empty_entry;
      end else begin : g_above
         assign lower = entries[i+1];
      end
      itp_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .shift_down (stack_op.push),
         .shift_up   (stack_op.pop),
         .upper      (upper),
         .lower      (lower),
         .entry      (entries[i])
      );
   end

   assign stack_stat.top  = entries[0];
   assign stack_stat.full = entries[STACK_DEPTH-1].valid;

   itp_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .stack_op   (stack_op),
      .stack_stat (stack_stat)
   );

endmodule
